### design/ffl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit allocator package
// Types, constants and small helper functions shared by the allocator.
// ----------------------------------------------------------------------------
package ffl_pkg;

  localparam int unsigned ArenaBytes   = 1024;
  localparam int unsigned GranuleBytes = 16;
  localparam int unsigned MaxGranules  = ArenaBytes / GranuleBytes;
  localparam int unsigned IdxW         = $clog2(MaxGranules);
  localparam int unsigned LinkW        = IdxW + 1;

  localparam logic [LinkW-1:0] NO_LINK = LinkW'(MaxGranules);
  localparam logic [LinkW-1:0] MIN_GRANULES = LinkW'(2);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [10:0] request_bytes;
    logic [9:0]  release_address;
  } in_word_t;

  typedef struct packed {
    logic [9:0] block_address;
    logic       granted;
  } out_word_t;

  typedef struct packed {
    logic [LinkW-1:0] size;
    logic [LinkW-1:0] next;
  } entry_t;

  function automatic logic [LinkW-1:0] follow(input logic [LinkW-1:0] nx,
                                              input logic [LinkW-1:0] gran);
    return (nx < gran) ? nx : NO_LINK;
  endfunction

  function automatic logic [LinkW-1:0] sat_size(input logic [LinkW+1:0] s,
                                                input logic [LinkW-1:0] gran);
    return (s > {2'b00, gran}) ? gran : s[LinkW-1:0];
  endfunction

endpackage

### design/first_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit free-list allocator with coalescing
// Address-ordered free list in a granule-indexed table, first-fit allocate
// with splitting, and free with merging of both neighbours.
// ----------------------------------------------------------------------------
// An allocate reads one list entry per step of the walk, then writes back the
// chosen entry and its predecessor; a free walks the list with a read and a
// compare per entry, then reads the freed block and its successor and writes
// back the freed block and its predecessor. Refused and ignored words skip the walk.
// One word is in flight at a time; the result is held until it is taken.
// After reset, and after each write of arena_bytes, the arena is written as one free block.
module first_fit_free_list_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ffl_pkg::in_word_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ffl_pkg::out_word_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i
);

  localparam int unsigned LW = ffl_pkg::LinkW;
  localparam int unsigned IW = ffl_pkg::IdxW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_WALK, S_A_WCUR, S_A_WPRV, S_F_CHK, S_F_RD,
    S_F_RDND, S_F_RDNX, S_F_WND, S_F_WPR, S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [LW-1:0]      gran_q, gran_d;
  logic [LW-1:0]      head_q, head_d;
  logic [LW:0]        need_q, need_d;
  logic [IW-1:0]      nd_q, nd_d;
  logic [LW-1:0]      cur_q, cur_d;
  logic [LW-1:0]      prev_q, prev_d;
  logic [LW-1:0]      steps_q, steps_d;
  logic [LW-1:0]      link_q, link_d;
  ffl_pkg::entry_t    prev_ent_q, prev_ent_d;
  ffl_pkg::entry_t    nd_ent_q, nd_ent_d;
  ffl_pkg::entry_t    wr_q, wr_d;
  ffl_pkg::out_word_t out_q, out_d;

  ffl_pkg::entry_t    mem [ffl_pkg::MaxGranules];
  ffl_pkg::entry_t    rdata;
  logic               mem_en, mem_we;
  logic [IW-1:0]      mem_addr;
  ffl_pkg::entry_t    mem_wdata;

  logic [11:0]        req_sum;
  logic [6:0]         cfg_g;
  logic [LW+1:0]      sum_a, sum_b;
  logic [LW-1:0]      fc;
  logic               split;

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        rdata <= mem[mem_addr];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    gran_d     = gran_q;
    head_d     = head_q;
    need_d     = need_q;
    nd_d       = nd_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    steps_d    = steps_q;
    link_d     = link_q;
    prev_ent_d = prev_ent_q;
    nd_ent_d   = nd_ent_q;
    wr_d       = wr_q;
    out_d      = out_q;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    req_sum    = {1'b0, in_data_i.request_bytes} + 12'(ffl_pkg::GranuleBytes - 1);
    cfg_g      = cfg_wdata_i[10:4];
    sum_a      = '0;
    sum_b      = '0;
    fc         = ffl_pkg::follow(rdata.next, gran_q);
    split      = 1'b0;

    unique case (state_q)
      S_INIT: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = '0;
        mem_wdata = '{size: gran_q - LW'(1), next: ffl_pkg::NO_LINK};
        head_d    = '0;
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !cfg_we_i) begin
          prev_d  = ffl_pkg::NO_LINK;
          steps_d = '0;
          if (in_data_i.command == ffl_pkg::CMD_ALLOC) begin
            need_d = req_sum[11:4];
            if (head_q < gran_q) begin
              cur_d    = head_q;
              mem_en   = 1'b1;
              mem_addr = head_q[IW-1:0];
              state_d  = S_A_WALK;
            end else begin
              out_d   = '0;
              state_d = S_OUT;
            end
          end else begin
            out_d.block_address = in_data_i.release_address;
            out_d.granted       = 1'b0;
            if (in_data_i.release_address[9:4] == '0 ||
                {1'b0, in_data_i.release_address[9:4] - IW'(1)} >= gran_q) begin
              state_d = S_OUT;
            end else begin
              nd_d    = in_data_i.release_address[9:4] - IW'(1);
              cur_d   = ffl_pkg::follow(head_q, gran_q);
              state_d = S_F_CHK;
            end
          end
        end
      end
      S_A_WALK: begin
        if (need_q > {1'b0, rdata.size}) begin
          if (steps_q >= gran_q || fc == ffl_pkg::NO_LINK) begin
            out_d   = '0;
            state_d = S_OUT;
          end else begin
            steps_d    = steps_q + LW'(1);
            prev_d     = cur_q;
            prev_ent_d = rdata;
            cur_d      = fc;
            mem_en     = 1'b1;
            mem_addr   = fc[IW-1:0];
          end
        end else begin
          sum_a = {2'b00, cur_q} + {1'b0, need_q} + (LW+2)'(1);
          split = ({2'b00, rdata.size} >= {1'b0, need_q} + (LW+2)'(2)) &&
                  (sum_a < {2'b00, gran_q});
          if (split) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = sum_a[IW-1:0];
            mem_wdata = '{size: rdata.size - LW'(1) - need_q[LW-1:0], next: fc};
            link_d    = sum_a[LW-1:0];
            wr_d      = '{size: need_q[LW-1:0], next: sum_a[LW-1:0]};
          end else begin
            link_d    = fc;
            wr_d      = rdata;
          end
          state_d = S_A_WCUR;
        end
      end
      S_A_WCUR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = cur_q[IW-1:0];
        mem_wdata = wr_q;
        state_d   = S_A_WPRV;
      end
      S_A_WPRV: begin
        if (prev_q == ffl_pkg::NO_LINK) begin
          head_d = link_q;
        end else begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = prev_q[IW-1:0];
          mem_wdata = '{size: prev_ent_q.size, next: link_q};
        end
        sum_a = {2'b00, cur_q} + (LW+2)'(1);
        out_d.block_address = {sum_a[5:0], 4'b0000};
        out_d.granted       = 1'b1;
        state_d             = S_OUT;
      end
      S_F_CHK: begin
        mem_en = 1'b1;
        if (cur_q == ffl_pkg::NO_LINK || {1'b0, nd_q} < cur_q) begin
          mem_addr = nd_q;
          state_d  = S_F_RDND;
        end else if (steps_q >= gran_q) begin
          cur_d    = ffl_pkg::NO_LINK;
          mem_addr = nd_q;
          state_d  = S_F_RDND;
        end else begin
          steps_d  = steps_q + LW'(1);
          mem_addr = cur_q[IW-1:0];
          state_d  = S_F_RD;
        end
      end
      S_F_RD: begin
        prev_d     = cur_q;
        prev_ent_d = rdata;
        cur_d      = fc;
        state_d    = S_F_CHK;
      end
      S_F_RDND: begin
        nd_ent_d = rdata;
        if (cur_q == ffl_pkg::NO_LINK) begin
          wr_d    = '{size: rdata.size, next: ffl_pkg::NO_LINK};
          state_d = S_F_WND;
        end else begin
          mem_en   = 1'b1;
          mem_addr = cur_q[IW-1:0];
          state_d  = S_F_RDNX;
        end
      end
      S_F_RDNX: begin
        sum_a = {3'b000, nd_q} + {2'b00, nd_ent_q.size} + (LW+2)'(1);
        sum_b = {2'b00, nd_ent_q.size} + {2'b00, rdata.size} + (LW+2)'(1);
        if (sum_a == {2'b00, cur_q}) begin
          wr_d = '{size: ffl_pkg::sat_size(sum_b, gran_q), next: fc};
        end else begin
          wr_d = '{size: nd_ent_q.size, next: cur_q};
        end
        state_d = S_F_WND;
      end
      S_F_WND: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = nd_q;
        mem_wdata = wr_q;
        sum_a = {2'b00, prev_q} + {2'b00, prev_ent_q.size} + (LW+2)'(1);
        sum_b = {2'b00, prev_ent_q.size} + {2'b00, wr_q.size} + (LW+2)'(1);
        out_d.granted = 1'b1;
        if (prev_q == ffl_pkg::NO_LINK) begin
          head_d  = {1'b0, nd_q};
          state_d = S_OUT;
        end else begin
          if (sum_a == (LW+2)'(nd_q)) begin
            wr_d = '{size: ffl_pkg::sat_size(sum_b, gran_q),
                     next: ffl_pkg::follow(wr_q.next, gran_q)};
          end else begin
            wr_d = '{size: prev_ent_q.size, next: {1'b0, nd_q}};
          end
          state_d = S_F_WPR;
        end
      end
      S_F_WPR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = prev_q[IW-1:0];
        mem_wdata = wr_q;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      if (cfg_g > 7'(ffl_pkg::MaxGranules)) begin
        gran_d = ffl_pkg::NO_LINK;
      end else if (cfg_g < 7'(ffl_pkg::MIN_GRANULES)) begin
        gran_d = ffl_pkg::MIN_GRANULES;
      end else begin
        gran_d = cfg_g[LW-1:0];
      end
      steps_d = '0;
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      gran_q     <= ffl_pkg::NO_LINK;
      head_q     <= '0;
      need_q     <= '0;
      nd_q       <= '0;
      cur_q      <= ffl_pkg::NO_LINK;
      prev_q     <= ffl_pkg::NO_LINK;
      steps_q    <= '0;
      link_q     <= ffl_pkg::NO_LINK;
      prev_ent_q <= '0;
      nd_ent_q   <= '0;
      wr_q       <= '0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      gran_q     <= gran_d;
      head_q     <= head_d;
      need_q     <= need_d;
      nd_q       <= nd_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      steps_q    <= steps_d;
      link_q     <= link_d;
      prev_ent_q <= prev_ent_d;
      nd_ent_q   <= nd_ent_d;
      wr_q       <= wr_d;
      out_q      <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_we_i;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  a_gran_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gran_q >= ffl_pkg::MIN_GRANULES && gran_q <= ffl_pkg::NO_LINK)
    else $error("Granule count out of range.");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= gran_q)
    else $error("List walk exceeded one pass over the arena.");

  a_head_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= ffl_pkg::NO_LINK)
    else $error("Head of the free list holds an impossible link.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A second word was taken while one is in flight.");

endmodule
